@@ rtl/core/mwo_pkg.sv @@
package mwo_pkg;

  typedef struct packed {
    logic        [31:0] stamp_sec;
    logic        [29:0] stamp_nsec;
    logic signed [31:0] wheel_tick_0;
    logic signed [31:0] wheel_tick_1;
    logic signed [31:0] wheel_tick_2;
    logic signed [31:0] wheel_tick_3;
  } in_t;

  typedef struct packed {
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] yaw_rate;
    logic        [31:0] out_sec;
    logic        [29:0] out_nsec;
    logic               valid_res;
  } out_t;

  typedef enum logic [3:0] {
    CFG_RADIUS = 4'd0,
    CFG_LPW    = 4'd1,
    CFG_CPR    = 4'd2,
    CFG_GEAR   = 4'd3
  } cfg_idx_t;

  localparam int CFG_DW = 20;
  localparam int MW     = 128;
  localparam int BW     = 35;

  localparam logic [29:0]   NS_PER_S  = 30'd1000000000;
  localparam logic [MW-1:0] TWO_PI_NS = MW'(64'd411775 * 64'd1000000000);

  typedef struct packed {
    logic          start;
    logic [MW-1:0] a;
    logic [BW-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic          busy;
    logic          done;
    logic [MW-1:0] p;
  } mul_rsp_t;

  typedef struct packed {
    logic start;
    logic neg;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

@@ rtl/core/mecanum_wheel_odometry.sv @@
// Channel  Ports                            Direction  Moves
// in       in_valid in_ready in_data        input      one sample transaction
// out      out_valid out_ready out_data     output     one velocity transaction
// cfg      cfg_we cfg_index cfg_data        input      one register write
//
// Each item passes through a shift-and-add multiplier that walks one
// multiplier bit a cycle through interval, divisor and numerator products, and
// a restoring divider that yields one quotient bit a cycle for each velocity.
// A reload skips every product; a nonpositive interval ends after the first one.
// Synchronous active-low reset clears history and control; no clearing pass.
// A stalled result is held in the output register while the next item works.
module mecanum_wheel_odometry #(
  parameter int TICK_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  mwo_pkg::in_t                in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output mwo_pkg::out_t               out_data,
  input  logic                        cfg_we,
  input  logic [3:0]                  cfg_index,
  input  logic [mwo_pkg::CFG_DW-1:0]  cfg_data
);
  import mwo_pkg::*;

  localparam int DW = (FRAC_BITS + 116 > 142) ? FRAC_BITS + 116 : 142;
  localparam int SW = TICK_WIDTH + 3;

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_DT   = 9'b000000010,
    ST_CPR  = 9'b000000100,
    ST_GEAR = 9'b000001000,
    ST_LPW  = 9'b000010000,
    ST_RK   = 9'b000100000,
    ST_NMUL = 9'b001000000,
    ST_DIV  = 9'b010000000,
    ST_DONE = 9'b100000000
  } state_t;

  function automatic logic [BW-1:0] abs_mag(input logic signed [SW-1:0] s);
    logic [SW-1:0] m;
    m = s[SW-1] ? $unsigned(-s) : $unsigned(s);
    return BW'(m);
  endfunction

  logic [15:0] radius_r, cpr_r, gear_r;
  logic [19:0] lpw_r;

  state_t state_r, state_nxt;
  logic [TICK_WIDTH-1:0] last_tick_r [4];
  logic [31:0]           last_sec_r;
  logic [29:0]           last_nsec_r;
  logic                  first_r;

  logic signed [SW-1:0] sum_r [3], sum_nxt [3];
  logic signed [31:0]   res_r [3], res_nxt [3];
  logic [29:0]   nsec_r, nsec_nxt, lnsec_r, lnsec_nxt;
  logic [31:0]   osec_r, osec_nxt;
  logic [MW-1:0] d_r, d_nxt, dy_r, dy_nxt, rk_r, rk_nxt;
  logic [1:0]    idx_r, idx_nxt;
  logic          vres_r, vres_nxt;

  mul_req_t mul_req_r, mul_req_nxt;
  mul_rsp_t mul_rsp;
  div_ctl_t div_ctl_r, div_ctl_nxt;
  div_sts_t div_sts;
  logic [DW-1:0]      div_x_r, div_x_nxt, div_y_r, div_y_nxt;
  logic signed [31:0] div_q;

  logic          out_valid_r, out_valid_nxt;
  out_t          out_data_r, out_data_nxt;

  logic                  accept;
  logic                  go;
  logic [TICK_WIDTH-1:0] dl [4];
  logic signed [SW-1:0]  de [4];
  logic signed [63:0]    dt_s;
  logic                  dt_pos;

  assign accept = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE);

  assign dl[0] = in_data.wheel_tick_0[TICK_WIDTH-1:0] - last_tick_r[0];
  assign dl[1] = in_data.wheel_tick_1[TICK_WIDTH-1:0] - last_tick_r[1];
  assign dl[2] = in_data.wheel_tick_2[TICK_WIDTH-1:0] - last_tick_r[2];
  assign dl[3] = in_data.wheel_tick_3[TICK_WIDTH-1:0] - last_tick_r[3];

  always_comb begin
    for (int i = 0; i < 4; i++) de[i] = SW'($signed(dl[i]));
  end

  assign go = !first_r && (in_data.stamp_sec >= last_sec_r) &&
              (cpr_r != '0) && (gear_r != '0) && (lpw_r != '0);

  assign dt_s = $signed({2'b00, mul_rsp.p[61:0]}) + $signed({34'd0, nsec_r})
              - $signed({34'd0, lnsec_r});
  assign dt_pos = !dt_s[63] && (dt_s != 64'sd0);

  always_comb begin
    state_nxt   = state_r;
    sum_nxt     = sum_r;
    res_nxt     = res_r;
    nsec_nxt    = nsec_r;
    lnsec_nxt   = lnsec_r;
    osec_nxt    = osec_r;
    d_nxt       = d_r;
    dy_nxt      = dy_r;
    rk_nxt      = rk_r;
    idx_nxt     = idx_r;
    vres_nxt    = vres_r;
    mul_req_nxt = mul_req_r;
    mul_req_nxt.start = 1'b0;
    div_ctl_nxt = div_ctl_r;
    div_ctl_nxt.start = 1'b0;
    div_x_nxt   = div_x_r;
    div_y_nxt   = div_y_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          sum_nxt[0] = de[0] + de[1] + de[2] + de[3];
          sum_nxt[1] = -de[0] + de[1] + de[2] - de[3];
          sum_nxt[2] = -de[0] + de[1] - de[2] + de[3];
          for (int i = 0; i < 3; i++) res_nxt[i] = '0;
          vres_nxt  = 1'b0;
          nsec_nxt  = in_data.stamp_nsec;
          lnsec_nxt = last_nsec_r;
          osec_nxt  = in_data.stamp_sec;
          if (go) begin
            mul_req_nxt.start = 1'b1;
            mul_req_nxt.a     = MW'(NS_PER_S);
            mul_req_nxt.b     = BW'(in_data.stamp_sec - last_sec_r);
            state_nxt         = ST_DT;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_DT: begin
        if (mul_rsp.done) begin
          if (dt_pos) begin
            vres_nxt          = 1'b1;
            mul_req_nxt.start = 1'b1;
            mul_req_nxt.a     = MW'($unsigned(dt_s));
            mul_req_nxt.b     = BW'(cpr_r);
            state_nxt         = ST_CPR;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_CPR: begin
        if (mul_rsp.done) begin
          mul_req_nxt.start = 1'b1;
          mul_req_nxt.a     = mul_rsp.p;
          mul_req_nxt.b     = BW'(gear_r);
          state_nxt         = ST_GEAR;
        end
      end
      ST_GEAR: begin
        if (mul_rsp.done) begin
          d_nxt             = mul_rsp.p;
          mul_req_nxt.start = 1'b1;
          mul_req_nxt.a     = mul_rsp.p;
          mul_req_nxt.b     = BW'(lpw_r);
          state_nxt         = ST_LPW;
        end
      end
      ST_LPW: begin
        if (mul_rsp.done) begin
          dy_nxt            = mul_rsp.p;
          mul_req_nxt.start = 1'b1;
          mul_req_nxt.a     = TWO_PI_NS;
          mul_req_nxt.b     = BW'(radius_r);
          state_nxt         = ST_RK;
        end
      end
      ST_RK: begin
        if (mul_rsp.done) begin
          rk_nxt            = mul_rsp.p;
          idx_nxt           = 2'd0;
          mul_req_nxt.start = 1'b1;
          mul_req_nxt.a     = mul_rsp.p;
          mul_req_nxt.b     = abs_mag(sum_r[0]);
          state_nxt         = ST_NMUL;
        end
      end
      ST_NMUL: begin
        if (mul_rsp.done) begin
          div_ctl_nxt.start = 1'b1;
          div_ctl_nxt.neg   = sum_r[idx_r][SW-1];
          if (idx_r == 2'd2) begin
            div_x_nxt = DW'(mul_rsp.p) << (FRAC_BITS + 16);
            div_y_nxt = DW'(dy_r) << 26;
          end else begin
            div_x_nxt = DW'(mul_rsp.p) << FRAC_BITS;
            div_y_nxt = DW'(d_r) << 26;
          end
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_sts.done) begin
          res_nxt[idx_r] = div_q;
          if (idx_r == 2'd2) begin
            state_nxt = ST_DONE;
          end else begin
            idx_nxt           = idx_r + 2'd1;
            mul_req_nxt.start = 1'b1;
            mul_req_nxt.a     = rk_r;
            mul_req_nxt.b     = abs_mag(sum_r[idx_r + 2'd1]);
            state_nxt         = ST_NMUL;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt.vel_x     = res_r[0];
          out_data_nxt.vel_y     = res_r[1];
          out_data_nxt.yaw_rate  = res_r[2];
          out_data_nxt.out_sec   = osec_r;
          out_data_nxt.out_nsec  = nsec_r;
          out_data_nxt.valid_res = vres_r;
          out_valid_nxt          = 1'b1;
          state_nxt              = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      out_valid_r     <= 1'b0;
      mul_req_r       <= '0;
      div_ctl_r       <= '0;
      first_r         <= 1'b1;
      last_sec_r      <= '0;
      last_nsec_r     <= '0;
      for (int i = 0; i < 4; i++) last_tick_r[i] <= '0;
    end else begin
      state_r         <= state_nxt;
      out_valid_r     <= out_valid_nxt;
      mul_req_r       <= mul_req_nxt;
      div_ctl_r       <= div_ctl_nxt;
      if (accept) begin
        first_r        <= 1'b0;
        last_sec_r     <= in_data.stamp_sec;
        last_nsec_r    <= in_data.stamp_nsec;
        last_tick_r[0] <= in_data.wheel_tick_0[TICK_WIDTH-1:0];
        last_tick_r[1] <= in_data.wheel_tick_1[TICK_WIDTH-1:0];
        last_tick_r[2] <= in_data.wheel_tick_2[TICK_WIDTH-1:0];
        last_tick_r[3] <= in_data.wheel_tick_3[TICK_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    sum_r         <= sum_nxt;
    res_r         <= res_nxt;
    nsec_r        <= nsec_nxt;
    lnsec_r       <= lnsec_nxt;
    osec_r        <= osec_nxt;
    d_r           <= d_nxt;
    dy_r          <= dy_nxt;
    rk_r          <= rk_nxt;
    idx_r         <= idx_nxt;
    vres_r        <= vres_nxt;
    div_x_r       <= div_x_nxt;
    div_y_r       <= div_y_nxt;
    out_data_r    <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= 16'd4588;
      lpw_r    <= 20'd24183;
      cpr_r    <= 16'd42;
      gear_r   <= 16'd1280;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RADIUS: radius_r <= cfg_data[15:0];
        CFG_LPW:    lpw_r    <= cfg_data[19:0];
        CFG_CPR:    cpr_r    <= cfg_data[15:0];
        CFG_GEAR:   gear_r   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  mwo_sermul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req_r),
    .rsp   (mul_rsp)
  );

  mwo_serdiv #(.DW(DW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (div_ctl_r),
    .x     (div_x_r),
    .y     (div_y_r),
    .sts   (div_sts),
    .q     (div_q)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_unit_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(mul_rsp.busy && div_sts.busy))
    else $error("multiplier and divider busy together");

  a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.done |-> (state_r == ST_DIV))
    else $error("divider finished outside the divide step");

  a_one_at_once: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready)
    else $error("second transaction taken while one is at work");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.valid_res) |->
      (out_data.vel_x == 32'sd0 && out_data.vel_y == 32'sd0 &&
       out_data.yaw_rate == 32'sd0))
    else $error("invalid result carries nonzero velocity");

endmodule

@@ rtl/core/mwo_sermul.sv @@
module mwo_sermul (
  input  logic              clk,
  input  logic              rst_n,
  input  mwo_pkg::mul_req_t req,
  output mwo_pkg::mul_rsp_t rsp
);
  import mwo_pkg::*;

  logic          busy_r, busy_nxt;
  logic [MW-1:0] a_r, a_nxt;
  logic [MW-1:0] p_r, p_nxt;
  logic [BW-1:0] b_r, b_nxt;

  always_comb begin
    busy_nxt = busy_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    p_nxt    = p_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      a_nxt    = req.a;
      b_nxt    = req.b;
      p_nxt    = '0;
    end else if (busy_r) begin
      if (b_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        if (b_r[0]) p_nxt = p_r + a_r;
        a_nxt = {a_r[MW-2:0], 1'b0};
        b_nxt = {1'b0, b_r[BW-1:1]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) busy_r <= 1'b0;
    else        busy_r <= busy_nxt;
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
    p_r <= p_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = busy_r && (b_r == '0);
  assign rsp.p    = p_r;

endmodule

@@ rtl/core/mwo_serdiv.sv @@
module mwo_serdiv #(
  parameter int DW = 142
) (
  input  logic               clk,
  input  logic               rst_n,
  input  mwo_pkg::div_ctl_t  ctl,
  input  logic [DW-1:0]      x,
  input  logic [DW-1:0]      y,
  output mwo_pkg::div_sts_t  sts,
  output logic signed [31:0] q
);
  import mwo_pkg::*;

  logic          busy_r, busy_nxt;
  logic [5:0]    cnt_r, cnt_nxt;
  logic          ovf_r, ovf_nxt;
  logic          neg_r, neg_nxt;
  logic [DW-1:0] r_r, r_nxt;
  logic [DW-1:0] y_r, y_nxt;
  logic [31:0]   xl_r, xl_nxt;
  logic [31:0]   q_r, q_nxt;
  logic [DW:0]   rs, diff;
  logic          ge;
  logic [31:0]   lim, mag;

  assign rs   = {r_r, xl_r[31]};
  assign ge   = rs >= {1'b0, y_r};
  assign diff = rs - {1'b0, y_r};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    ovf_nxt  = ovf_r;
    neg_nxt  = neg_r;
    r_nxt    = r_r;
    y_nxt    = y_r;
    xl_nxt   = xl_r;
    q_nxt    = q_r;
    if (ctl.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 6'd32;
      r_nxt    = x >> 32;
      ovf_nxt  = (x >> 32) >= y;
      xl_nxt   = x[31:0];
      y_nxt    = y;
      q_nxt    = '0;
      neg_nxt  = ctl.neg;
    end else if (busy_r) begin
      if (cnt_r == 6'd0) begin
        busy_nxt = 1'b0;
      end else begin
        r_nxt   = ge ? diff[DW-1:0] : rs[DW-1:0];
        q_nxt   = {q_r[30:0], ge};
        xl_nxt  = {xl_r[30:0], 1'b0};
        cnt_nxt = cnt_r - 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ovf_r <= ovf_nxt;
    neg_r <= neg_nxt;
    r_r   <= r_nxt;
    y_r   <= y_nxt;
    xl_r  <= xl_nxt;
    q_r   <= q_nxt;
  end

  assign lim = neg_r ? 32'h8000_0000 : 32'h7FFF_FFFF;
  assign mag = (ovf_r || (q_r > lim)) ? lim : q_r;
  assign q   = neg_r ? $signed(32'd0 - mag) : $signed(mag);

  assign sts.busy = busy_r;
  assign sts.done = busy_r && (cnt_r == 6'd0);

endmodule

@@ tb/mecanum_wheel_odometry_test.sv @@
module mecanum_wheel_odometry_test;
  import mwo_pkg::*;

  localparam int          IDLE_LIMIT  = 20000;
  localparam int          SETTLE      = 400;
  localparam logic [3:0]  CFG_UNUSED  = 4'd9;
  localparam int          FRAC        = 16;

  class velocity_scoreboard;
    logic [15:0] radius;
    logic [19:0] lpw;
    logic [15:0] cpr;
    logic [15:0] gear;
    logic [31:0] prev_ticks [4];
    logic [31:0] prev_sec;
    logic [29:0] prev_nsec;
    bit          fresh;
    out_t        pending_vel [$];
    int          errors;
    int          checked;
    int          computed;
    int          saturated;

    function void reset_state();
      radius = 16'd4588;
      lpw    = 20'd24183;
      cpr    = 16'd42;
      gear   = 16'd1280;
      foreach (prev_ticks[i]) prev_ticks[i] = '0;
      prev_sec  = '0;
      prev_nsec = '0;
      fresh     = 1'b1;
      errors    = 0;
      checked   = 0;
      computed  = 0;
      saturated = 0;
    endfunction

    function void set_reg(logic [3:0] idx, logic [CFG_DW-1:0] val);
      case (idx)
        CFG_RADIUS: radius = val[15:0];
        CFG_LPW:    lpw    = val[19:0];
        CFG_CPR:    cpr    = val[15:0];
        CFG_GEAR:   gear   = val[15:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] wheel_speed(longint sum, logic [255:0] den, bit yaw);
      logic [255:0] num;
      logic [255:0] quo;
      logic [255:0] lim;
      longint       mag;
      bit           neg;
      neg = sum < 0;
      mag = neg ? -sum : sum;
      if (mag == 0) return '0;
      num = 256'(mag);
      num = num * 256'(radius);
      num = num * 256'(411775);
      num = num * 256'(1000000000);
      num = num << (FRAC + (yaw ? 16 : 0));
      quo = num / den;
      lim = neg ? 256'h8000_0000 : 256'h7FFF_FFFF;
      if (quo > lim) begin
        quo = lim;
        saturated++;
      end
      return neg ? (32'd0 - quo[31:0]) : quo[31:0];
    endfunction

    function void note_sample(in_t s);
      out_t         r;
      longint       dt;
      longint       d [4];
      logic [31:0]  cur [4];
      logic [31:0]  u;
      logic [255:0] den;
      logic [255:0] deny;
      cur[0] = s.wheel_tick_0;
      cur[1] = s.wheel_tick_1;
      cur[2] = s.wheel_tick_2;
      cur[3] = s.wheel_tick_3;
      r = '0;
      r.out_sec  = s.stamp_sec;
      r.out_nsec = s.stamp_nsec;
      if (!fresh && s.stamp_sec >= prev_sec) begin
        dt = longint'(s.stamp_sec - prev_sec) * 64'd1000000000
           + longint'(s.stamp_nsec) - longint'(prev_nsec);
        for (int i = 0; i < 4; i++) begin
          u = cur[i] - prev_ticks[i];
          d[i] = longint'($signed(u));
        end
        if (dt > 0 && cpr != 0 && gear != 0 && lpw != 0) begin
          den  = 256'(dt) * 256'(cpr) * 256'(gear);
          den  = den << 26;
          deny = den * 256'(lpw);
          r.vel_x    = wheel_speed(d[0] + d[1] + d[2] + d[3], den, 1'b0);
          r.vel_y    = wheel_speed(-d[0] + d[1] + d[2] - d[3], den, 1'b0);
          r.yaw_rate = wheel_speed(-d[0] + d[1] - d[2] + d[3], deny, 1'b1);
          r.valid_res = 1'b1;
          computed++;
        end
      end
      foreach (cur[i]) prev_ticks[i] = cur[i];
      prev_sec  = s.stamp_sec;
      prev_nsec = s.stamp_nsec;
      fresh     = 1'b0;
      pending_vel.push_back(r);
    endfunction

    function void check_velocity(out_t got);
      out_t want;
      checked++;
      if (pending_vel.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      want = pending_vel.pop_front();
      if (got.vel_x !== want.vel_x) begin
        $display("%0t: vel_x expected %0d got %0d", $time, want.vel_x, got.vel_x);
        errors++;
      end
      if (got.vel_y !== want.vel_y) begin
        $display("%0t: vel_y expected %0d got %0d", $time, want.vel_y, got.vel_y);
        errors++;
      end
      if (got.yaw_rate !== want.yaw_rate) begin
        $display("%0t: yaw_rate expected %0d got %0d", $time, want.yaw_rate,
                 got.yaw_rate);
        errors++;
      end
      if (got.out_sec !== want.out_sec) begin
        $display("%0t: out_sec expected %0d got %0d", $time, want.out_sec, got.out_sec);
        errors++;
      end
      if (got.out_nsec !== want.out_nsec) begin
        $display("%0t: out_nsec expected %0d got %0d", $time, want.out_nsec,
                 got.out_nsec);
        errors++;
      end
      if (got.valid_res !== want.valid_res) begin
        $display("%0t: valid_res expected %0b got %0b", $time, want.valid_res,
                 got.valid_res);
        errors++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  in_t               in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_t              out_data;
  logic              cfg_we = 1'b0;
  logic [3:0]        cfg_index = '0;
  logic [CFG_DW-1:0] cfg_data = '0;

  velocity_scoreboard sb;
  bit      no_idle;
  bit      hold_req;
  int      idle_cycles = 0;
  longint  cur_sec;
  longint  cur_nsec;
  logic [31:0] cur_ticks [4];

  mecanum_wheel_odometry u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  function int gap_len();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 20);
    return $urandom_range(50, 200);
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_velocity(out_data);
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int g;
    wait (rst_n);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (3000) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        g = gap_len();
        if (g > 0) begin
          out_ready <= 1'b0;
          repeat (g) @(posedge clk);
        end
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic push_sample(in_t s);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    do @(posedge clk); while (!in_ready);
    sb.note_sample(s);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_vel.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [3:0] idx, logic [CFG_DW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(int rad, int lw, int cp, int gr);
    wait_drained();
    write_reg(CFG_RADIUS, CFG_DW'(rad));
    write_reg(CFG_LPW, CFG_DW'(lw));
    write_reg(CFG_CPR, CFG_DW'(cp));
    write_reg(CFG_GEAR, CFG_DW'(gr));
  endtask

  task automatic send_stamp(longint sec, longint nsec, logic [31:0] t0, logic [31:0] t1,
                            logic [31:0] t2, logic [31:0] t3);
    in_t s;
    s.stamp_sec    = sec[31:0];
    s.stamp_nsec   = nsec[29:0];
    s.wheel_tick_0 = t0;
    s.wheel_tick_1 = t1;
    s.wheel_tick_2 = t2;
    s.wheel_tick_3 = t3;
    cur_sec  = sec;
    cur_nsec = nsec;
    cur_ticks[0] = t0;
    cur_ticks[1] = t1;
    cur_ticks[2] = t2;
    cur_ticks[3] = t3;
    push_sample(s);
  endtask

  task automatic send_motion();
    longint dt;
    longint ns;
    int     r;
    logic [31:0] t [4];
    r = $urandom_range(0, 99);
    if (r < 70) dt = $urandom_range(1, 200000000);
    else if (r < 85) dt = $urandom_range(1, 1000);
    else dt = longint'($urandom_range(1, 5)) * 1000000000 + $urandom_range(0, 999999999);
    ns = cur_nsec + dt;
    for (int i = 0; i < 4; i++) begin
      r = $urandom_range(0, 99);
      if (r < 80) t[i] = cur_ticks[i] + 32'($signed($urandom_range(0, 4000)) - 2000);
      else if (r < 95) t[i] = cur_ticks[i] + 32'($signed($urandom_range(0, 400000)) - 200000);
      else t[i] = cur_ticks[i] + $urandom;
    end
    send_stamp(cur_sec + ns / 1000000000, ns % 1000000000, t[0], t[1], t[2], t[3]);
  endtask

  task automatic send_noise();
    int r;
    r = $urandom_range(0, 3);
    case (r)
      0: send_stamp($urandom, $urandom_range(0, 999999999), $urandom, $urandom,
                    $urandom, $urandom);
      1: send_stamp(cur_sec, cur_nsec, cur_ticks[0] + 1, cur_ticks[1], cur_ticks[2],
                    cur_ticks[3]);
      2: send_stamp(cur_sec, $urandom_range(0, 999999999), $urandom, $urandom,
                    $urandom, $urandom);
      default: send_stamp(cur_sec - $urandom_range(1, 3), cur_nsec, cur_ticks[0],
                          cur_ticks[1], cur_ticks[2], cur_ticks[3]);
    endcase
  endtask

  task automatic random_run(int count, bit with_hold);
    for (int k = 0; k < count; k++) begin
      if (k % 60 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if (with_hold && k == count / 2) hold_req = 1'b1;
      if ($urandom_range(0, 99) < 85) send_motion();
      else send_noise();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    sb = new();
    sb.reset_state();
    no_idle  = 1'b0;
    hold_req = 1'b0;
    foreach (cur_ticks[i]) cur_ticks[i] = '0;
    cur_sec  = 0;
    cur_nsec = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_stamp(10, 0, 0, 0, 0, 0);
    send_stamp(10, 50000000, 100, 100, 100, 100);
    send_stamp(10, 50000000, 200, 300, 100, 0);
    send_stamp(10, 1000, 300, 300, 300, 300);
    send_stamp(9, 0, 0, 0, 0, 0);
    send_stamp(9, 1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_stamp(9, 2, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_stamp(9, 3, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0000, 32'hFFFF_FFFF);
    send_stamp(9, 4, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0000, 32'hFFFF_FFFF);
    send_stamp(9, 20000000, 32'hFFFF_FF00, 32'h100, 32'hFFFF_FF00, 32'h100);
    send_stamp(32'hFFFF_FFFE, 999999999, 0, 0, 0, 0);
    send_stamp(32'hFFFF_FFFF, 999999999, 5000, -5000, 5000, -5000);
    send_stamp(32'hFFFF_FFFF, 999999999, 6000, -6000, 6000, -6000);
    send_stamp(0, 0, 1, 2, 3, 4);
    send_stamp(4, 536870912, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);

    wait_drained();
    write_reg(CFG_UNUSED, '1);
    random_run(220, 1'b1);

    configure(1, 1, 1, 1);
    random_run(180, 1'b0);

    configure(65535, 20'hFFFFF, 16'hFFFF, 16'hFFFF);
    random_run(180, 1'b0);

    configure(65535, 1, 1, 1);
    random_run(180, 1'b1);

    wait_drained();
    configure($urandom_range(1, 65535), $urandom_range(1, 20'hFFFFF),
              $urandom_range(1, 65535), $urandom_range(1, 65535));
    random_run(180, 1'b0);

    configure(4588, 24183, 42, 1280);
    random_run(180, 1'b0);

    configure($urandom_range(1, 200), $urandom_range(1, 5000), $urandom_range(1, 20),
              $urandom_range(1, 300));
    random_run(160, 1'b0);

    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_vel.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("checked %0d velocity transactions: %0d computed, %0d saturated fields",
             sb.checked, sb.computed, sb.saturated);
    $display("covered reloads, zero and negative intervals, wrapping ticks, six settings");
    if (sb.errors == 0 && sb.pending_vel.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
